// File: rtl/mrot_pkg.sv
// ---------------------------------------------------------------------------
// mrot_pkg
// Shared types and codes for the square matrix store with clockwise rotate.
// ---------------------------------------------------------------------------
package mrot_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned APB_W    = 32;
  localparam int unsigned PADDR_W  = 3;

  // configuration register indexes
  localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_ROTATE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     out_of_range;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic rd_en;
    logic wr_en;
  } rot_ctl_t;

endpackage

// File: rtl/matrix_rotate_90_clockwise_top.sv
// ---------------------------------------------------------------------------
// matrix_rotate_90_clockwise_top
// Square matrix store of signed 32-bit elements with write, read and an
// in-place 90 degree clockwise rotate of the configured n by n matrix.
// ---------------------------------------------------------------------------
// Writes and reads may follow back to back unless a read result waits on a
// stalled output; a read result passes the store read register, then the
// output register. A rotate holds off input until the sequencer is idle: it
// does floor(n*n/4) four-way swaps, each through states RD_LU, RD_RU, RD_RD,
// RD_LD, WR_LD, WR_LU on the single read and single write port of the store.
// The store is not cleared after reset; read only positions already written.
// ---------------------------------------------------------------------------
module matrix_rotate_90_clockwise_top #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mrot_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mrot_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mrot_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [mrot_pkg::APB_W-1:0]    cfg_pwdata,
  output logic [mrot_pkg::APB_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW    = (SW > mrot_pkg::SIZE_W) ? SW : mrot_pkg::SIZE_W;
  localparam int unsigned AW    = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;

  logic [mrot_pkg::SIZE_W-1:0] matrix_size_r;
  logic [SW-1:0]               side;
  logic                        cfg_write;

  logic                        in_accept, in_range, cmd_wr, cmd_rd, rot_start;
  logic [AW-1:0]               cmd_addr;
  logic                        out_free;
  logic                        pend_r, pend_oor_r;
  logic                        out_valid_r;
  mrot_pkg::out_item_t         out_item_r;

  logic [mrot_pkg::DATA_W-1:0] mem [DEPTH];
  logic [mrot_pkg::DATA_W-1:0] rdata_r;
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [mrot_pkg::DATA_W-1:0] mem_wdata;

  mrot_pkg::rot_ctl_t          rot_ctl;
  logic [AW-1:0]               rot_rd_addr, rot_wr_addr;
  logic [mrot_pkg::DATA_W-1:0] rot_wr_data;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == mrot_pkg::REG_MATRIX_SIZE) begin
      cfg_prdata = mrot_pkg::APB_W'(matrix_size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r <= '0;
    end else if (cfg_write && (cfg_paddr[2] == mrot_pkg::REG_MATRIX_SIZE)) begin
      matrix_size_r <= cfg_pwdata[mrot_pkg::SIZE_W-1:0];
    end
  end

  assign side = (CW'(matrix_size_r) > CW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(matrix_size_r);

  // command decode
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = rot_ctl.busy || (pend_r && !out_free);
  assign in_accept = in_valid && !in_stall;
  assign in_range  = (CW'(in_data.row) < CW'(side)) && (CW'(in_data.col) < CW'(side));
  assign cmd_addr  = AW'(in_data.row) * AW'(MAX_SIDE) + AW'(in_data.col);
  assign cmd_wr    = in_accept && (in_data.cmd == mrot_pkg::CMD_WRITE) && in_range;
  assign cmd_rd    = in_accept && (in_data.cmd == mrot_pkg::CMD_READ) && in_range;
  assign rot_start = in_accept && (in_data.cmd == mrot_pkg::CMD_ROTATE) && (side > SW'(1));

  mrot_rot_seq #(
    .MAX_SIDE (MAX_SIDE)
  ) u_rot_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rot_start),
    .side    (side),
    .rd_data (rdata_r),
    .ctl     (rot_ctl),
    .rd_addr (rot_rd_addr),
    .wr_addr (rot_wr_addr),
    .wr_data (rot_wr_data)
  );

  // element store
  assign mem_we    = rot_ctl.busy ? rot_ctl.wr_en : cmd_wr;
  assign mem_re    = rot_ctl.busy ? rot_ctl.rd_en : cmd_rd;
  assign mem_waddr = rot_ctl.busy ? rot_wr_addr : cmd_addr;
  assign mem_raddr = rot_ctl.busy ? rot_rd_addr : cmd_addr;
  assign mem_wdata = rot_ctl.busy ? rot_wr_data : in_data.value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // read result path: hold the pending read until the output register frees
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      pend_oor_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept && (in_data.cmd == mrot_pkg::CMD_READ)) begin
        pend_r     <= 1'b1;
        pend_oor_r <= !in_range;
      end else if (pend_r && out_free) begin
        pend_r <= 1'b0;
      end
      if (pend_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      out_item_r.read_value   <= pend_oor_r ? '0 : $signed(rdata_r);
      out_item_r.out_of_range <= pend_oor_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !out_free) |=> (pend_r && $stable(rdata_r) && $stable(pend_oor_r)))
    else $error("pending read lost or overwritten");

  a_rot_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rot_ctl.wr_en || rot_ctl.rd_en) |-> rot_ctl.busy)
    else $error("rotate store access while idle");

  a_rot_start: assert property (@(posedge clk) disable iff (!rst_n)
    rot_start |=> (rot_ctl.busy && rot_ctl.rd_en && !rot_ctl.wr_en))
    else $error("rotate did not begin with a read");

  a_no_read_during_rot: assert property (@(posedge clk) disable iff (!rst_n)
    rot_ctl.busy |-> !pend_r)
    else $error("read result pending during rotate");

endmodule

// File: rtl/mrot_rot_seq.sv
// ---------------------------------------------------------------------------
// mrot_rot_seq
// Rotate sequencer: walks the rings from the outside in and performs one
// four-way element swap per step through the shared store ports.
// ---------------------------------------------------------------------------
module mrot_rot_seq #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [$clog2(MAX_SIDE+1)-1:0]        side,
  input  logic [mrot_pkg::DATA_W-1:0]          rd_data,
  output mrot_pkg::rot_ctl_t                   ctl,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] rd_addr,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] wr_addr,
  output logic [mrot_pkg::DATA_W-1:0]          wr_data
);

  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned IW = $clog2(MAX_SIDE);
  localparam int unsigned AW = $clog2(MAX_SIDE * MAX_SIDE);

  typedef enum logic [6:0] {
    RS_IDLE  = 7'b0000001,
    RS_RD_LU = 7'b0000010,
    RS_RD_RU = 7'b0000100,
    RS_RD_RD = 7'b0001000,
    RS_RD_LD = 7'b0010000,
    RS_WR_LD = 7'b0100000,
    RS_WR_LU = 7'b1000000
  } rot_state_t;

  rot_state_t                  state_r, state_nxt;
  logic [IW-1:0]               first_r, first_nxt;
  logic [SW-1:0]               len_r, len_nxt;
  logic [IW-1:0]               i_r, i_nxt;
  logic [mrot_pkg::DATA_W-1:0] held_r, held_nxt;

  logic [IW-1:0] last, fi, li;
  logic [IW-1:0] rd_row, rd_col, wr_row, wr_col;
  logic          step_last;

  assign last      = IW'(SW'(first_r) + len_r - SW'(1));
  assign fi        = first_r + i_r;
  assign li        = last - i_r;
  assign step_last = (i_r == IW'(len_r - SW'(2)));

  always_comb begin
    rd_row = first_r;
    rd_col = fi;
    unique case (state_r)
      RS_RD_RU: begin
        rd_row = fi;
        rd_col = last;
      end
      RS_RD_RD: begin
        rd_row = last;
        rd_col = li;
      end
      RS_RD_LD: begin
        rd_row = li;
        rd_col = first_r;
      end
      default: begin
        rd_row = first_r;
        rd_col = fi;
      end
    endcase
  end

  always_comb begin
    wr_row = first_r;
    wr_col = fi;
    unique case (state_r)
      RS_RD_RD: begin
        wr_row = fi;
        wr_col = last;
      end
      RS_RD_LD: begin
        wr_row = last;
        wr_col = li;
      end
      RS_WR_LD: begin
        wr_row = li;
        wr_col = first_r;
      end
      default: begin
        wr_row = first_r;
        wr_col = fi;
      end
    endcase
  end

  assign rd_addr = AW'(rd_row) * AW'(MAX_SIDE) + AW'(rd_col);
  assign wr_addr = AW'(wr_row) * AW'(MAX_SIDE) + AW'(wr_col);
  assign wr_data = held_r;

  assign ctl.busy  = (state_r != RS_IDLE);
  assign ctl.rd_en = (state_r == RS_RD_LU) || (state_r == RS_RD_RU) ||
                     (state_r == RS_RD_RD) || (state_r == RS_RD_LD);
  assign ctl.wr_en = (state_r == RS_RD_RD) || (state_r == RS_RD_LD) ||
                     (state_r == RS_WR_LD) || (state_r == RS_WR_LU);

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    len_nxt   = len_r;
    i_nxt     = i_r;
    held_nxt  = held_r;
    unique case (state_r)
      RS_IDLE: begin
        if (start) begin
          state_nxt = RS_RD_LU;
          first_nxt = '0;
          len_nxt   = side;
          i_nxt     = '0;
        end
      end
      RS_RD_LU: state_nxt = RS_RD_RU;
      RS_RD_RU: begin
        held_nxt  = rd_data;
        state_nxt = RS_RD_RD;
      end
      RS_RD_RD: begin
        held_nxt  = rd_data;
        state_nxt = RS_RD_LD;
      end
      RS_RD_LD: begin
        held_nxt  = rd_data;
        state_nxt = RS_WR_LD;
      end
      RS_WR_LD: begin
        held_nxt  = rd_data;
        state_nxt = RS_WR_LU;
      end
      RS_WR_LU: begin
        if (!step_last) begin
          i_nxt     = i_r + IW'(1);
          state_nxt = RS_RD_LU;
        end else if (len_r > SW'(3)) begin
          first_nxt = first_r + IW'(1);
          len_nxt   = len_r - SW'(2);
          i_nxt     = '0;
          state_nxt = RS_RD_LU;
        end else begin
          state_nxt = RS_IDLE;
        end
      end
      default: state_nxt = RS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
      first_r <= '0;
      len_r   <= '0;
      i_r     <= '0;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
      i_r     <= i_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule
